// ===== hw/rtl/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int CAPACITY      = 64;
  localparam int PRIORITY_BITS = 16;
  localparam int PAYLOAD_BITS  = 16;
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [PAYLOAD_BITS-1:0]  payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [PAYLOAD_BITS-1:0]  out_payload;
    logic [CNT_W-1:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } store_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } store_rd_t;

  // microcode step addresses
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_CMP,
    S_PUSH_WR,
    S_POP_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_DN_WR,
    S_DONE
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_POS_ZERO,
    C_PARENT_GE,
    C_NO_CHILD,
    C_MV_GE,
    C_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {RD_NONE, RD_PARENT, RD_ROOT_LAST, RD_CHILDREN} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_PARENT, WR_CHILD, WR_MV} wr_sel_t;
  typedef enum logic [1:0] {POS_HOLD, POS_PARENT, POS_CHILD} pos_sel_t;
  typedef enum logic [1:0] {ACT_ALWAYS, ACT_HIT, ACT_MISS} act_t;

  typedef struct packed {
    cond_t    cond;
    step_t    jmp;
    step_t    nxt;
    rd_sel_t  rd;
    wr_sel_t  wr;
    pos_sel_t pos;
    act_t     act;
    logic     ld_in;
    logic     ld_pop;
    logic     ld_out;
  } ucw_t;

  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    w.cond   = C_ALWAYS;
    w.jmp    = S_IDLE;
    w.nxt    = S_IDLE;
    w.rd     = RD_NONE;
    w.wr     = WR_NONE;
    w.pos    = POS_HOLD;
    w.act    = ACT_ALWAYS;
    w.ld_in  = 1'b0;
    w.ld_pop = 1'b0;
    w.ld_out = 1'b0;
    case (step)
      S_IDLE: begin
        w.cond  = C_DISPATCH;
        w.nxt   = S_IDLE;
        w.rd    = RD_ROOT_LAST;
        w.act   = ACT_HIT;
        w.ld_in = 1'b1;
      end
      S_PUSH_CHK: begin
        w.cond = C_POS_ZERO;
        w.jmp  = S_PUSH_WR;
        w.nxt  = S_PUSH_CMP;
        w.rd   = RD_PARENT;
      end
      S_PUSH_CMP: begin
        w.cond = C_PARENT_GE;
        w.jmp  = S_PUSH_WR;
        w.nxt  = S_PUSH_CHK;
        w.wr   = WR_PARENT;
        w.pos  = POS_PARENT;
        w.act  = ACT_MISS;
      end
      S_PUSH_WR: begin
        w.jmp = S_DONE;
        w.wr  = WR_MV;
      end
      S_POP_LD: begin
        w.jmp    = S_DN_CHK;
        w.ld_pop = 1'b1;
      end
      S_DN_CHK: begin
        w.cond = C_NO_CHILD;
        w.jmp  = S_DN_WR;
        w.nxt  = S_DN_CMP;
        w.rd   = RD_CHILDREN;
      end
      S_DN_CMP: begin
        w.cond = C_MV_GE;
        w.jmp  = S_DN_WR;
        w.nxt  = S_DN_CHK;
        w.wr   = WR_CHILD;
        w.pos  = POS_CHILD;
        w.act  = ACT_MISS;
      end
      S_DN_WR: begin
        w.jmp = S_DONE;
        w.wr  = WR_MV;
      end
      S_DONE: begin
        w.cond   = C_OUT_FREE;
        w.jmp    = S_IDLE;
        w.nxt    = S_DONE;
        w.act    = ACT_HIT;
        w.ld_out = 1'b1;
      end
      default: begin
        w.jmp = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // decode jump taken on an input transfer
  function automatic step_t dispatch_target(input logic func, input logic reject);
    step_t t;
    if (reject) begin
      t = S_DONE;
    end else if (func == FUNC_POP) begin
      t = S_POP_LD;
    end else begin
      t = S_PUSH_CHK;
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/max_heap_priority_queue.sv =====
// Binary max-heap priority queue of CAPACITY (priority, payload) entries. Each input transfer
// is a push or a pop and yields exactly one result transfer carrying a status, the popped entry
// (zero for a push or a rejected pop) and the occupancy after the operation. A push on a full
// heap and a pop on an empty heap are reported and leave the heap untouched. The block works on
// one operation at a time: a small microcode program walks the heap through a store with one
// write port and two registered read ports, one tree level at a time: a push climbs from the
// new leaf and a pop descends from the root. With 64 entries the tree is 6 levels below the
// root. in_ready is high while the sequencer sits in its idle step; a finished result waits
// in the output register, and the next operation is taken and worked on meanwhile, stalling
// only at its own final step.
module max_heap_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mhpq_pkg::out_item_t out_item
);
  import mhpq_pkg::*;

  // sequencer
  step_t upc_r, upc_nxt;
  ucw_t  ucw;
  logic  hit;
  logic  act_en;

  // datapath registers
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  entry_t           mv_r, mv_nxt;
  entry_t           res_r, res_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  // store interface
  store_wr_t store_wr;
  store_rd_t store_rd;
  entry_t    rd_a;
  entry_t    rd_b;

  // heap arithmetic
  logic             xfer;
  logic             reject;
  logic [IDX_W-1:0] parent_idx;
  logic [CNT_W:0]   child_l;
  logic [CNT_W:0]   child_rt;
  logic             no_child;
  logic             right_ok;
  logic             take_right;
  entry_t           sel_entry;
  logic [IDX_W-1:0] sel_idx;
  logic             out_free;

  mhpq_store u_store (
    .clk       (clk),
    .wr        (store_wr),
    .rd        (store_rd),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign ucw = ucode_rom(upc_r);

  assign in_ready = (upc_r == S_IDLE);
  assign xfer     = in_valid && in_ready;

  // full push or empty pop
  assign reject = (in_item.func == FUNC_POP) ? (cnt_r == '0)
                                             : (cnt_r == CNT_W'(CAPACITY));

  assign parent_idx = (pos_r - IDX_W'(1)) >> 1;
  assign child_l    = (CNT_W + 1)'({pos_r, 1'b1});
  assign child_rt   = child_l + (CNT_W + 1)'(1);
  assign no_child   = child_l >= {1'b0, cnt_r};
  assign right_ok   = child_rt < {1'b0, cnt_r};

  // equal priorities go to the right child
  assign take_right = right_ok && (rd_b.prio >= rd_a.prio);
  assign sel_entry  = take_right ? rd_b : rd_a;
  assign sel_idx    = take_right ? child_rt[IDX_W-1:0] : child_l[IDX_W-1:0];

  assign out_free = !out_valid_r || out_ready;

  // condition select
  always_comb begin
    case (ucw.cond)
      C_ALWAYS:    hit = 1'b1;
      C_DISPATCH:  hit = xfer;
      C_POS_ZERO:  hit = (pos_r == '0);
      C_PARENT_GE: hit = (rd_a.prio >= mv_r.prio);
      C_NO_CHILD:  hit = no_child;
      C_MV_GE:     hit = (mv_r.prio >= sel_entry.prio);
      C_OUT_FREE:  hit = out_free;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    case (ucw.act)
      ACT_ALWAYS: act_en = 1'b1;
      ACT_HIT:    act_en = hit;
      ACT_MISS:   act_en = !hit;
      default:    act_en = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (ucw.cond == C_DISPATCH) begin
      upc_nxt = xfer ? dispatch_target(in_item.func, reject) : ucw.nxt;
    end else begin
      upc_nxt = hit ? ucw.jmp : ucw.nxt;
    end
  end

  // store read addresses, data is registered and comes back in the next cycle
  always_comb begin
    store_rd.addr_a = '0;
    store_rd.addr_b = '0;
    case (ucw.rd)
      RD_PARENT: begin
        store_rd.addr_a = parent_idx;
      end
      RD_ROOT_LAST: begin
        store_rd.addr_a = '0;
        store_rd.addr_b = IDX_W'(cnt_r - CNT_W'(1));
      end
      RD_CHILDREN: begin
        store_rd.addr_a = child_l[IDX_W-1:0];
        store_rd.addr_b = child_rt[IDX_W-1:0];
      end
      default: begin
        store_rd.addr_a = '0;
      end
    endcase
  end

  // store write, always at the current hole
  always_comb begin
    store_wr.en   = (ucw.wr != WR_NONE) && act_en;
    store_wr.addr = pos_r;
    case (ucw.wr)
      WR_PARENT: store_wr.data = rd_a;
      WR_CHILD:  store_wr.data = sel_entry;
      WR_MV:     store_wr.data = mv_r;
      default:   store_wr.data = mv_r;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    mv_nxt       = mv_r;
    res_nxt      = res_r;
    status_nxt   = status_r;
    out_item_nxt = out_item_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (ucw.ld_in && act_en) begin
      mv_nxt.prio = in_item.priority_req;
      mv_nxt.tag  = in_item.payload;
      res_nxt     = '0;
      if (reject) begin
        status_nxt = (in_item.func == FUNC_POP) ? STATUS_EMPTY : STATUS_FULL;
      end else begin
        status_nxt = STATUS_OK;
        if (in_item.func == FUNC_POP) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          pos_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          pos_nxt = cnt_r[IDX_W-1:0];
        end
      end
    end

    // root is the result, last entry moves to the top
    if (ucw.ld_pop && act_en) begin
      res_nxt = rd_a;
      mv_nxt  = rd_b;
    end

    if (act_en) begin
      case (ucw.pos)
        POS_PARENT: pos_nxt = parent_idx;
        POS_CHILD:  pos_nxt = sel_idx;
        default:    pos_nxt = pos_nxt;
      endcase
    end

    if (ucw.ld_out && act_en) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.status       = status_r;
      out_item_nxt.out_priority = res_r.prio;
      out_item_nxt.out_payload  = res_r.tag;
      out_item_nxt.occupancy    = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    mv_r       <= mv_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/mhpq_store.sv =====
module mhpq_store (
  input  logic               clk,
  input  mhpq_pkg::store_wr_t wr,
  input  mhpq_pkg::store_rd_t rd,
  output mhpq_pkg::entry_t    rd_data_a,
  output mhpq_pkg::entry_t    rd_data_b
);
  import mhpq_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_data_a_r;
  entry_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a_r <= mem[rd.addr_a];
    rd_data_b_r <= mem[rd.addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ===== verif/max_heap_priority_queue_test.sv =====
`timescale 1ns / 1ps

module max_heap_priority_queue_test;
  import mhpq_pkg::*;

  // drain time at the end, enough to cover any late result
  localparam int unsigned DRAIN_CYCLES = 40;
  // worst correct spacing between transfers is an input gap plus the busy time
  // plus an output stall, so this limit is many times over
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_OPS = 1900;

  // traffic shapes for the random part
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // operations waiting to go out, and results the heap owes us, oldest first
  in_item_t  ops_to_send [$];
  out_item_t results_due [$];

  // our own copy of the heap, updated at every accepted transfer
  entry_t      shadow_heap [CAPACITY];
  int unsigned shadow_count = 0;

  // transfer flags seen at the last rising edge, used by the falling-edge drivers
  logic        in_fire_q  = 1'b0;
  logic        out_fire_q = 1'b0;

  int unsigned in_hold    = 0;
  int unsigned in_calm    = 0;
  int unsigned out_hold   = 0;
  int unsigned out_calm   = 0;
  int unsigned ops_taken  = 0;
  int unsigned total_ops  = 0;
  int unsigned idle_run   = 0;
  int unsigned mismatches = 0;
  logic        stuck      = 1'b0;

  max_heap_priority_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected result of one operation; updates the shadow heap like the block should
  function automatic out_item_t heap_apply(input in_item_t op);
    out_item_t   res;
    entry_t      mover;
    int unsigned pos;
    int unsigned up;
    int unsigned kid;
    logic        settled;
    res = '0;
    res.status = STATUS_OK;
    mover.prio = op.priority_req;
    mover.tag = op.payload;
    settled = 1'b0;
    pos = 0;
    if (op.func == FUNC_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        // sift up, stopping below a parent that is greater or equal
        pos = shadow_count;
        shadow_count++;
        while (pos != 0 && !settled) begin
          up = (pos - 1) >> 1;
          if (shadow_heap[up].prio >= mover.prio) begin
            settled = 1'b1;
          end else begin
            shadow_heap[pos] = shadow_heap[up];
            pos = up;
          end
        end
        shadow_heap[pos] = mover;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.out_priority = shadow_heap[0].prio;
        res.out_payload = shadow_heap[0].tag;
        shadow_count--;
        mover = shadow_heap[shadow_count];
        // sift down; on a tie between children the right one wins
        while (!settled) begin
          kid = 2 * pos + 1;
          if (kid >= shadow_count) begin
            settled = 1'b1;
          end else begin
            if (kid + 1 < shadow_count && shadow_heap[kid + 1].prio >= shadow_heap[kid].prio) begin
              kid = kid + 1;
            end
            if (mover.prio >= shadow_heap[kid].prio) begin
              settled = 1'b1;
            end else begin
              shadow_heap[pos] = shadow_heap[kid];
              pos = kid;
            end
          end
        end
        shadow_heap[pos] = mover;
      end
    end
    res.occupancy = CNT_W'(shadow_count);
    return res;
  endfunction

  // cycles to hold off before the next transfer; now and then a run of back-to-back ones
  function automatic int unsigned draw_wait(inout int unsigned calm);
    int unsigned n;
    if (calm > 0) begin
      calm--;
      n = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      n = 0;
    end else begin
      n = $urandom_range(0, 14);
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s at op %0d: expected %0h, got %0h", what, ops_taken, want, got);
    end
  endtask

  task automatic queue_op(input logic func, input logic [PRIORITY_BITS-1:0] prio,
                          input logic [PAYLOAD_BITS-1:0] tag);
    in_item_t op;
    op.func = func;
    op.priority_req = prio;
    op.payload = tag;
    ops_to_send.push_back(op);
  endtask

  // input driver: new item only once the previous one has been transferred
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire_q)) begin
      if (in_hold > 0) begin
        in_hold--;
        in_valid <= 1'b0;
      end else if (ops_to_send.size() != 0) begin
        in_item <= ops_to_send.pop_front();
        in_valid <= 1'b1;
        in_hold = draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure; a stall only counts down while a result is waiting
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire_q) begin
        out_hold = draw_wait(out_calm);
      end
      if (out_hold > 0) begin
        if (out_valid) begin
          out_hold--;
        end
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check results, predict accepted operations, watch for a hang
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected result", '0, 64'(out_item));
      end else begin
        want = results_due.pop_front();
        if (out_item.status !== want.status) begin
          flag_mismatch("status", 64'(want.status), 64'(out_item.status));
        end
        if (out_item.out_priority !== want.out_priority) begin
          flag_mismatch("out_priority", 64'(want.out_priority), 64'(out_item.out_priority));
        end
        if (out_item.out_payload !== want.out_payload) begin
          flag_mismatch("out_payload", 64'(want.out_payload), 64'(out_item.out_payload));
        end
        if (out_item.occupancy !== want.occupancy) begin
          flag_mismatch("occupancy", 64'(want.occupancy), 64'(out_item.occupancy));
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      results_due.push_back(heap_apply(in_item));
      ops_taken++;
    end
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= STALL_LIMIT) begin
      stuck = 1'b1;
    end
    in_fire_q <= rst_n && in_valid && in_ready;
    out_fire_q <= rst_n && out_valid && out_ready;
  end

  initial begin : main
    mix_t                     mix;
    int unsigned              push_pct;
    logic [PRIORITY_BITS-1:0] prio;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_heap[i] = '0;
    end

    // directed: pop on empty with all-ones ignored fields, extremes, ties, drain to empty
    queue_op(FUNC_POP, '1, '1);
    queue_op(FUNC_PUSH, '0, '0);
    queue_op(FUNC_PUSH, '1, '1);
    queue_op(FUNC_PUSH, 16'h8000, 16'h0001);
    queue_op(FUNC_PUSH, 16'h8000, 16'h0002);
    queue_op(FUNC_PUSH, 16'h8000, 16'h0003);
    queue_op(FUNC_PUSH, '0, 16'h5555);
    // equal to the root, must not climb past it
    queue_op(FUNC_PUSH, '1, 16'hAAAA);
    repeat (8) begin
      queue_op(FUNC_POP, PRIORITY_BITS'($urandom), PAYLOAD_BITS'($urandom));
    end

    // random: stretches that fill up to full, drain to empty, or hover
    while (ops_to_send.size() < RANDOM_OPS + 16) begin
      mix = mix_t'($urandom_range(0, 2));
      case (mix)
        MIX_FILL:  push_pct = 92;
        MIX_DRAIN: push_pct = 8;
        default:   push_pct = 52;
      endcase
      repeat ($urandom_range(24, 120)) begin
        // crowd priorities onto the extremes and a few small values to force ties
        case ($urandom_range(0, 5))
          0:       prio = '0;
          1:       prio = '1;
          2:       prio = PRIORITY_BITS'($urandom_range(0, 3));
          default: prio = PRIORITY_BITS'($urandom);
        endcase
        queue_op(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP, prio,
                 PAYLOAD_BITS'($urandom));
      end
    end
    total_ops = ops_to_send.size();

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (!stuck && !(ops_taken == total_ops && results_due.size() == 0)) begin
      @(negedge clk);
    end
    // give a spurious extra result the chance to show up
    if (!stuck) begin
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    if (!stuck && mismatches == 0) begin
      $display("max_heap_priority_queue test passed");
    end else begin
      $display("max_heap_priority_queue test failed");
    end
    $finish;
  end

endmodule
